>>> hdl/shallow_water_face_flux_top_assert.svh
// assertion macros for the shallow-water face flux block
// used by the checker module; no other dependencies
`ifndef SHALLOW_WATER_FACE_FLUX_TOP_ASSERT_SVH
`define SHALLOW_WATER_FACE_FLUX_TOP_ASSERT_SVH

// concurrent assertion on a given clock and active-low reset
`define SWF_ASSERT_CLK(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define SWF_ASSERT(name, prop, msg) `SWF_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

>>> hdl/swf_pkg.sv
// shared widths, status codes and side-band struct of the face flux pipeline
// no dependencies
`default_nettype none

package swf_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned GRAV_W  = 31;
  localparam int unsigned NUM_W   = 64;
  localparam int unsigned DEN_W   = 31;
  localparam int unsigned QUO_W   = 31;
  localparam int unsigned ROOT_W  = 32;
  localparam int unsigned RAD_W   = 64;
  localparam int unsigned REM_W   = 35;
  // divider and square root both take this many register stages
  localparam int unsigned DIV_LAT = 32;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEPTH = 2'd1,
    ST_ROOT  = 2'd2
  } status_e;

  // per-item control that rides alongside the arithmetic units
  typedef struct packed {
    logic              dir;
    logic [DATA_W-1:0] mn;
    logic              nx_neg;
    logic              nx_zero;
    logic              ny_neg;
    logic              ny_zero;
    status_e           status;
  } swf_side_t;

endpackage

`default_nettype wire

>>> hdl/swf_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// depends on swf_pkg
`default_nettype none

module swf_div import swf_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             ovf_o
);

  localparam int unsigned STEPS = QUO_W;

  logic [DEN_W-1:0] rem_q [STEPS+1];
  logic [DEN_W-1:0] den_q [STEPS+1];
  logic [QUO_W-1:0] low_q [STEPS+1];
  logic [QUO_W-1:0] quo_q [STEPS+1];
  logic             ovf_q [STEPS+1];

  // entry stage: quotient fits only if num < den * 2^QUO_W
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= num_i[NUM_W-1:QUO_W] >= (NUM_W-QUO_W)'(den_i);
      rem_q[0] <= num_i[QUO_W+DEN_W-1:QUO_W];
      low_q[0] <= num_i[QUO_W-1:0];
      den_q[0] <= den_i;
      quo_q[0] <= '0;
    end
  end

  // one trial subtraction per stage, msb first
  for (genvar j = 1; j <= STEPS; j++) begin : g_step
    localparam int unsigned BIT = STEPS - j;
    logic [DEN_W:0] trial;
    logic           ge;

    assign trial = {rem_q[j-1], low_q[j-1][BIT]};
    assign ge    = trial >= {1'b0, den_q[j-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? DEN_W'(trial - {1'b0, den_q[j-1]}) : trial[DEN_W-1:0];
        quo_q[j] <= quo_q[j-1] | (QUO_W'(ge) << BIT);
        low_q[j] <= low_q[j-1];
        den_q[j] <= den_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
      end
    end
  end

  assign quo_o = quo_q[STEPS];
  assign ovf_o = ovf_q[STEPS];

endmodule

`default_nettype wire

>>> hdl/swf_sqrt.sv
// pipelined integer square root, one root bit per stage, floor result
// depends on swf_pkg
`default_nettype none

module swf_sqrt import swf_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [REM_W-1:0]  rem_q  [1:ROOT_W];
  logic [ROOT_W-1:0] root_q [1:ROOT_W];
  logic [RAD_W-1:0]  rad_q  [1:ROOT_W];

  for (genvar j = 1; j <= ROOT_W; j++) begin : g_step
    localparam int unsigned P = ROOT_W - j;
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [RAD_W-1:0]  rad_p;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    logic              ge;

    // first stage starts from the radicand with empty remainder
    if (j == 1) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
    end else begin : g_next
      assign rem_p  = rem_q[j-1];
      assign root_p = root_q[j-1];
      assign rad_p  = rad_q[j-1];
    end

    // bring down two radicand bits and try 4*root+1
    assign cur   = {rem_p[REM_W-3:0], rad_p[2*P+1 -: 2]};
    assign trial = {{(REM_W-ROOT_W-2){1'b0}}, root_p, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? (cur - trial) : cur;
        root_q[j] <= {root_p[ROOT_W-2:0], ge};
        rad_q[j]  <= rad_p;
      end
    end
  end

  assign root_o = root_q[ROOT_W];

endmodule

`default_nettype wire

>>> hdl/swf_delay.sv
// enabled shift line that keeps side data aligned with the long units
// depends on swf_pkg only through the widths given by the user
`default_nettype none

module swf_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] pipe_q [DEPTH];

  // shift on every pipeline advance
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= data_i;
      for (int i = 1; i < DEPTH; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign data_o = pipe_q[DEPTH-1];

endmodule

`default_nettype wire

>>> hdl/shallow_water_face_flux_top.sv
// top level of the shallow-water face flux pipeline
// depends on swf_pkg, swf_div, swf_sqrt, swf_delay
//
// Input channel in_valid_i/in_ready_o carries one cell state and face
// direction per transfer; output channel out_valid_o/out_ready_i carries the
// fluxes, nonconservative terms, wave speed and status of that item.
// cfg_valid_i/cfg_data_i write gravity (always ready); write it while idle.
// Results pass through 36 register stages: the input register, two stages
// of multiply and sign handling, 32 stages of the bit-per-stage divider and
// square root units, and the output register.
// Throughput is one item per cycle while the receiver does not stall; every stage advances together.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops; nothing is lost or repeated.
// Reset clears all valid bits and loads gravity with 9.81 in the fixed-point
// format; no clearing pass is needed.
`default_nettype none

module shallow_water_face_flux_top import swf_pkg::*; #(
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [GRAV_W-1:0]        cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     direction_i,
  input  logic signed [DATA_W-1:0] depth_i,
  input  logic signed [DATA_W-1:0] momentum_x_i,
  input  logic signed [DATA_W-1:0] momentum_y_i,
  input  logic signed [DATA_W-1:0] bathymetry_i,
  input  logic signed [DATA_W-1:0] depth_jump_i,
  input  logic signed [DATA_W-1:0] bathymetry_jump_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] flux_mass_o,
  output logic signed [DATA_W-1:0] flux_mom_x_o,
  output logic signed [DATA_W-1:0] flux_mom_y_o,
  output logic signed [DATA_W-1:0] ncp_mom_x_o,
  output logic signed [DATA_W-1:0] ncp_mom_y_o,
  output logic [GRAV_W-1:0]        max_speed_o,
  output logic [1:0]               status_o
);

  localparam logic [63:0] GRAV_RAW = ((64'd981 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [GRAV_W-1:0] GRAV_RST =
    (GRAV_RAW > 64'h7FFF_FFFF) ? {GRAV_W{1'b1}} : GRAV_RAW[GRAV_W-1:0];
  localparam int unsigned SHIFT = 2 * FRAC_BITS;
  localparam logic [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic adv;

  // gravity register
  logic [GRAV_W-1:0] gravity_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q <= GRAV_RST;
    end else if (cfg_valid_i) begin
      gravity_q <= cfg_data_i;
    end
  end

  // whole pipeline advances when the output register is empty or being read
  logic out_valid_q;
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // stage 1: input register
  logic                     v1_q;
  logic                     dir1_q;
  logic signed [DATA_W-1:0] h1_q, mx1_q, my1_q, b1_q;
  logic signed [DATA_W:0]   s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dir1_q <= direction_i;
      h1_q   <= depth_i;
      mx1_q  <= momentum_x_i;
      my1_q  <= momentum_y_i;
      b1_q   <= bathymetry_i;
      s1_q   <= {depth_jump_i[DATA_W-1], depth_jump_i}
              + {bathymetry_jump_i[DATA_W-1], bathymetry_jump_i};
    end
  end

  // stage 2: momentum products, g*|h|, h+b
  logic signed [DATA_W-1:0]   mn1;
  logic [DATA_W-1:0]          mn_mag1, h_mag1;
  logic signed [2*DATA_W-1:0] nx1, ny1;

  assign mn1     = dir1_q ? my1_q : mx1_q;
  assign nx1     = mn1 * mx1_q;
  assign ny1     = mn1 * my1_q;
  assign mn_mag1 = mn1[DATA_W-1] ? (~mn1 + 1'b1) : mn1;
  assign h_mag1  = h1_q[DATA_W-1] ? (~h1_q + 1'b1) : h1_q;

  logic                       v2_q;
  logic                       dir2_q;
  logic [DATA_W-1:0]          mn2_q;
  logic signed [2*DATA_W-1:0] nx2_q, ny2_q;
  logic [NUM_W-1:0]           umag2_q;
  logic [GRAV_W+DATA_W-1:0]   gh2_q;
  logic signed [DATA_W:0]     hb2_q;
  logic                       hpos2_q, hneg2_q;
  logic [DEN_W-1:0]           den2_q;
  logic signed [DATA_W:0]     s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dir2_q  <= dir1_q;
      mn2_q   <= mn1;
      nx2_q   <= nx1;
      ny2_q   <= ny1;
      umag2_q <= NUM_W'(mn_mag1) << FRAC_BITS;
      gh2_q   <= (GRAV_W+DATA_W)'(gravity_q) * (GRAV_W+DATA_W)'(h_mag1);
      hb2_q   <= {h1_q[DATA_W-1], h1_q} + {b1_q[DATA_W-1], b1_q};
      hpos2_q <= !h1_q[DATA_W-1] && (h1_q != '0);
      hneg2_q <= h1_q[DATA_W-1];
      den2_q  <= h1_q[DEN_W-1:0];
      s2_q    <= s1_q;
    end
  end

  // stage 3: magnitudes, radicand, ncp partial products, status
  logic [NUM_W-1:0]  nx_mag2, ny_mag2;
  logic [DATA_W:0]   s_mag2;
  swf_side_t         side2;

  assign nx_mag2 = nx2_q[NUM_W-1] ? (~nx2_q + 1'b1) : nx2_q;
  assign ny_mag2 = ny2_q[NUM_W-1] ? (~ny2_q + 1'b1) : ny2_q;
  assign s_mag2  = s2_q[DATA_W] ? (~s2_q + 1'b1) : s2_q;

  always_comb begin
    side2.dir     = dir2_q;
    side2.mn      = mn2_q;
    side2.nx_neg  = nx2_q[NUM_W-1];
    side2.nx_zero = nx2_q == '0;
    side2.ny_neg  = ny2_q[NUM_W-1];
    side2.ny_zero = ny2_q == '0;
    if (!hpos2_q) begin
      side2.status = ST_DEPTH;
    end else if (hb2_q[DATA_W]) begin
      side2.status = ST_ROOT;
    end else begin
      side2.status = ST_OK;
    end
  end

  logic                   v3_q;
  swf_side_t              side3_q;
  logic [NUM_W-1:0]       nxmag3_q, nymag3_q, umag3_q;
  logic [DEN_W-1:0]       den3_q;
  logic [RAD_W-1:0]       rad3_q;
  logic [2*DATA_W:0]      pplo3_q;
  logic [GRAV_W+DATA_W:0] pphi3_q;
  logic                   ncpneg3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side3_q   <= side2;
      nxmag3_q  <= nx_mag2;
      nymag3_q  <= ny_mag2;
      umag3_q   <= umag2_q;
      den3_q    <= den2_q;
      rad3_q    <= hb2_q[DATA_W] ? '0
                 : RAD_W'(gravity_q) * RAD_W'(hb2_q[DATA_W-1:0]);
      pplo3_q   <= (2*DATA_W+1)'(gh2_q[DATA_W-1:0]) * (2*DATA_W+1)'(s_mag2);
      pphi3_q   <= (GRAV_W+DATA_W+1)'(gh2_q[GRAV_W+DATA_W-1:DATA_W])
                 * (GRAV_W+DATA_W+1)'(s_mag2);
      ncpneg3_q <= hneg2_q != s2_q[DATA_W];
    end
  end

  // divider and square root units
  logic [QUO_W-1:0]  qx, qy, qu;
  logic              ox, oy, ou;
  logic [ROOT_W-1:0] root;

  swf_div u_div_x (
    .clk_i (clk_i), .en_i (adv), .num_i (nxmag3_q), .den_i (den3_q),
    .quo_o (qx), .ovf_o (ox)
  );

  swf_div u_div_y (
    .clk_i (clk_i), .en_i (adv), .num_i (nymag3_q), .den_i (den3_q),
    .quo_o (qy), .ovf_o (oy)
  );

  swf_div u_div_u (
    .clk_i (clk_i), .en_i (adv), .num_i (umag3_q), .den_i (den3_q),
    .quo_o (qu), .ovf_o (ou)
  );

  swf_sqrt u_sqrt (
    .clk_i (clk_i), .en_i (adv), .rad_i (rad3_q), .root_o (root)
  );

  // ncp: sum partial products, then scale and saturate
  localparam int unsigned PROD_W = 2*DATA_W + GRAV_W + 2;
  logic [PROD_W-1:0] prod4_q;
  logic              neg4_q;
  logic [PROD_W-1:0] qn4;
  logic [DATA_W-1:0] lim4, ncp4;
  logic [DATA_W-1:0] ncp5_q, ncp_dly;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod4_q <= PROD_W'(pplo3_q) + (PROD_W'(pphi3_q) << DATA_W);
      neg4_q  <= ncpneg3_q;
    end
  end

  assign qn4  = prod4_q >> SHIFT;
  assign lim4 = neg4_q ? SMIN : SMAX;
  always_comb begin
    if (qn4 > PROD_W'(lim4)) begin
      ncp4 = neg4_q ? SMIN : SMAX;
    end else begin
      ncp4 = neg4_q ? (~qn4[DATA_W-1:0] + 1'b1) : qn4[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ncp5_q <= ncp4;
    end
  end

  swf_delay #(.WIDTH(DATA_W), .DEPTH(DIV_LAT-2)) u_ncp_dly (
    .clk_i (clk_i), .en_i (adv), .data_i (ncp5_q), .data_o (ncp_dly)
  );

  // side data and valid bits alongside the long units
  logic [$bits(swf_side_t)-1:0] side_raw;
  swf_side_t                    side_o;

  swf_delay #(.WIDTH($bits(swf_side_t)), .DEPTH(DIV_LAT)) u_side_dly (
    .clk_i (clk_i), .en_i (adv), .data_i (side3_q), .data_o (side_raw)
  );
  assign side_o = swf_side_t'(side_raw);

  logic [DIV_LAT-1:0] vpipe_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpipe_q <= '0;
    end else if (adv) begin
      vpipe_q <= {vpipe_q[DIV_LAT-2:0], v3_q};
    end
  end

  // final assembly of the result
  logic [DATA_W-1:0] fx_d, fy_d;
  logic [GRAV_W-1:0] speed_d;
  logic [DATA_W:0]   speed_sum;

  always_comb begin
    if (side_o.status == ST_DEPTH) begin
      fx_d = side_o.nx_neg ? SMIN : (side_o.nx_zero ? '0 : SMAX);
      fy_d = side_o.ny_neg ? SMIN : (side_o.ny_zero ? '0 : SMAX);
    end else begin
      if (ox) begin
        fx_d = side_o.nx_neg ? SMIN : SMAX;
      end else begin
        fx_d = side_o.nx_neg ? (~{1'b0, qx} + 1'b1) : {1'b0, qx};
      end
      if (oy) begin
        fy_d = side_o.ny_neg ? SMIN : SMAX;
      end else begin
        fy_d = side_o.ny_neg ? (~{1'b0, qy} + 1'b1) : {1'b0, qy};
      end
    end
  end

  assign speed_sum = (DATA_W+1)'(qu) + (DATA_W+1)'(root);
  always_comb begin
    if (side_o.status != ST_OK || ou || speed_sum > (DATA_W+1)'(SMAX)) begin
      speed_d = {GRAV_W{1'b1}};
    end else begin
      speed_d = speed_sum[GRAV_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vpipe_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      flux_mass_o  <= side_o.mn;
      flux_mom_x_o <= fx_d;
      flux_mom_y_o <= fy_d;
      ncp_mom_x_o  <= side_o.dir ? '0 : ncp_dly;
      ncp_mom_y_o  <= side_o.dir ? ncp_dly : '0;
      max_speed_o  <= speed_d;
      status_o     <= side_o.status;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> hdl/swf_checker.sv
// port-level checks of the face flux block, bound to the top level
// depends on swf_pkg and shallow_water_face_flux_top_assert.svh
`default_nettype none

`include "shallow_water_face_flux_top_assert.svh"

module swf_checker import swf_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DATA_W-1:0] flux_mass_o,
  input logic signed [DATA_W-1:0] ncp_mom_x_o,
  input logic signed [DATA_W-1:0] ncp_mom_y_o,
  input logic [GRAV_W-1:0]        max_speed_o,
  input logic [1:0]               status_o
);

  // input side stalls exactly when a result is held back
  `SWF_ASSERT(a_ready_follows_out, in_ready_o == (!out_valid_o || out_ready_i), "ready mismatch")

  // any error status forces the saturated wave speed
  `SWF_ASSERT(a_err_speed, out_valid_o && status_o != ST_OK |-> max_speed_o == {GRAV_W{1'b1}}, "speed not saturated")

  // only the normal component carries the ncp term
  `SWF_ASSERT(a_ncp_one_side, out_valid_o |-> ncp_mom_x_o == '0 || ncp_mom_y_o == '0, "both ncp set")

  // a held result stays put
  `SWF_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(flux_mass_o), "result dropped")

endmodule

bind shallow_water_face_flux_top swf_checker u_swf_checker (.*);

`default_nettype wire
